@@ src/bcs_pkg.sv @@
// bezier curve sampler package: sizes, widths and the controller/datapath command types
// used by bcs_ctrl, bcs_datapath and bezier_curve_sampler; no dependencies
package bcs_pkg;

  localparam int MAX_POINTS = 32;
  localparam int COORD_BITS = 16;
  localparam int GUARD_BITS = 16;
  localparam int SEG_W      = 6;

  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W  = $clog2(MAX_POINTS);
  localparam int POINT_W = 3 * COORD_BITS;
  localparam int WORK_W  = COORD_BITS + GUARD_BITS;
  localparam int DIFF_W  = WORK_W + 1;
  localparam int PROD_W  = DIFF_W + SEG_W + 1;
  localparam int NUM_W   = PROD_W + 2;
  localparam int DEN_W   = SEG_W + 1;
  localparam int DCNT_W  = $clog2(NUM_W + 1);
  localparam int OUT_W   = 3 * COORD_BITS + SEG_W;
  localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8;
  localparam int IN_PAD  = ((POINT_W + 7) / 8) * 8;

  localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(20);

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic              cp_we;
    logic [ADDR_W-1:0] cp_addr;
    logic [1:0]        axis;
    logic              wk_we;
    logic [ADDR_W-1:0] wk_waddr;
    logic [ADDR_W-1:0] wk_raddr;
    logic              wk_src_cp;
    logic              load_a;
    logic              a_from_b;
    logic              load_b;
    logic              mul;
    logic              div_start;
    logic              save_axis;
    logic              load_out;
    logic              ovf;
    logic [SEG_W-1:0]  i;
    logic [SEG_W-1:0]  s;
  } bcs_cmd_t;

  typedef struct packed {
    logic div_busy;
  } bcs_stat_t;

endpackage

@@ src/bezier_curve_sampler.sv @@
// bezier curve sampler top level: joins controller and datapath to the stream ports
// depends on bcs_pkg, bcs_ctrl, bcs_datapath
//
// Control points arrive one item per cycle while the block is idle and are stored in
// order, up to 32; further points are dropped and flagged on every sample of that curve.
// The item with tlast set starts evaluation: segment_count+1 samples (zero counts as one)
// are computed by de Casteljau interpolation over the n stored points, one axis at a
// time, with a single serial rounding divider for every interpolation step. Output
// waits on m_tready while the output register is full; the input is not ready until
// the last sample has gone to the output register.
module bezier_curve_sampler import bcs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [SEG_W-1:0]   cfg_wdata,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [IN_PAD-1:0]  s_tdata,  // point_x, point_y, point_z
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_PAD-1:0] m_tdata,  // curve_x, curve_y, curve_z, sample_index
  output logic               m_tuser,  // points_dropped
  output logic               m_tlast
);

  bcs_cmd_t  cmd;
  bcs_stat_t stat;

  bcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_last   (s_tlast),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  bcs_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (s_tdata[POINT_W-1:0]),
    .out_data (m_tdata),
    .out_flag (m_tuser),
    .out_last (m_tlast)
  );

  a_last_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[OUT_W-1:3*COORD_BITS] != '0)
    else $error("last sample carries index zero");

  a_busy_after_final: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input ready right after final point");

  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_W-1:3*COORD_BITS] == '0 |-> !m_tlast)
    else $error("sample zero marked last");

endmodule

@@ src/bcs_datapath.sv @@
// bezier curve sampler datapath: control point and work memories, interpolation
// multiply, serial rounding divider, output register; uses bcs_pkg
module bcs_datapath import bcs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  bcs_cmd_t             cmd,
  output bcs_stat_t            stat,
  input  logic [POINT_W-1:0]   in_data,
  output logic [OUT_PAD-1:0]   out_data,
  output logic                 out_flag,
  output logic                 out_last
);

  logic [POINT_W-1:0]       cp_mem [MAX_POINTS];
  logic [POINT_W-1:0]       cp_q;
  logic signed [WORK_W-1:0] wk_mem [MAX_POINTS];
  logic signed [WORK_W-1:0] wk_q;

  logic signed [WORK_W-1:0] a, b;
  logic signed [PROD_W-1:0] prod;
  logic [NUM_W-1:0]         div_sh;
  logic [DEN_W-1:0]         rem;
  logic                     neg;
  logic [DCNT_W-1:0]        dcnt;
  logic                     busy;

  logic [COORD_BITS-1:0]    res_x, res_y, res_z;

  logic [COORD_BITS-1:0]    coord;
  logic signed [WORK_W-1:0] cp_word;
  logic signed [WORK_W-1:0] interp;
  logic signed [WORK_W-1:0] wk_wdata;
  logic signed [DIFF_W-1:0] diff_ext;
  logic signed [SEG_W:0]    i_ext;
  logic signed [NUM_W-1:0]  n2, q_signed;
  logic [NUM_W-1:0]         n2_mag;
  logic [DEN_W-1:0]         den;
  logic [DEN_W:0]           trial;
  logic signed [WORK_W:0]   rnd;
  logic signed [COORD_BITS:0] v;
  logic [COORD_BITS-1:0]    sat;

  always_comb begin
    case (cmd.axis)
      AXIS_X:  coord = cp_q[COORD_BITS-1:0];
      AXIS_Y:  coord = cp_q[2*COORD_BITS-1:COORD_BITS];
      AXIS_Z:  coord = cp_q[3*COORD_BITS-1:2*COORD_BITS];
      default: coord = cp_q[COORD_BITS-1:0];
    endcase
  end

  assign cp_word  = $signed({coord, {GUARD_BITS{1'b0}}});
  assign diff_ext = $signed({b[WORK_W-1], b}) - $signed({a[WORK_W-1], a});
  assign i_ext    = $signed({1'b0, cmd.i});
  assign den      = {cmd.s, 1'b0};
  assign n2       = $signed({prod[PROD_W-1], prod, 1'b0}) + $signed(NUM_W'(cmd.s));
  assign n2_mag   = n2[NUM_W-1] ? NUM_W'(-n2) : NUM_W'(n2);
  assign trial    = {rem, div_sh[NUM_W-1]};
  assign q_signed = neg ? -$signed(div_sh + NUM_W'(rem != '0)) : $signed(div_sh);
  assign interp   = a + q_signed[WORK_W-1:0];
  assign wk_wdata = cmd.wk_src_cp ? cp_word : interp;

  // drop guard bits with round half up, then saturate
  assign rnd = $signed({wk_q[WORK_W-1], wk_q}) + $signed((WORK_W+1)'(1) <<< (GUARD_BITS - 1));
  assign v   = rnd[WORK_W:GUARD_BITS];
  always_comb begin
    if (v[COORD_BITS] != v[COORD_BITS-1])
      sat = v[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
    else
      sat = v[COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.cp_we)
      cp_mem[cmd.cp_addr] <= in_data;
    cp_q <= cp_mem[cmd.cp_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wk_we)
      wk_mem[cmd.wk_waddr] <= wk_wdata;
    wk_q <= wk_mem[cmd.wk_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_a)
      a <= wk_q;
    else if (cmd.a_from_b)
      a <= b;
    if (cmd.load_b)
      b <= wk_q;
    if (cmd.mul)
      prod <= diff_ext * i_ext;
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      dcnt <= '0;
    end else if (cmd.div_start) begin
      busy   <= 1'b1;
      dcnt   <= DCNT_W'(NUM_W);
      div_sh <= n2_mag;
      rem    <= '0;
      neg    <= n2[NUM_W-1];
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem    <= DEN_W'(trial - {1'b0, den});
        div_sh <= {div_sh[NUM_W-2:0], 1'b1};
      end else begin
        rem    <= trial[DEN_W-1:0];
        div_sh <= {div_sh[NUM_W-2:0], 1'b0};
      end
      dcnt <= dcnt - 1'b1;
      if (dcnt == DCNT_W'(1))
        busy <= 1'b0;
    end
  end

  assign stat.div_busy = busy;

  always_ff @(posedge clk) begin
    if (cmd.save_axis) begin
      case (cmd.axis)
        AXIS_X:  res_x <= sat;
        AXIS_Y:  res_y <= sat;
        default: res_z <= sat;
      endcase
    end
    if (cmd.load_out) begin
      out_data <= OUT_PAD'({cmd.i, res_z, res_y, res_x});
      out_flag <= cmd.ovf;
      out_last <= (cmd.i == cmd.s);
    end
  end

endmodule

@@ src/bcs_ctrl.sv @@
// bezier curve sampler controller: point count, segment register and the
// sequencer that walks samples, axes and interpolation levels; uses bcs_pkg
module bcs_ctrl import bcs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [SEG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output bcs_cmd_t         cmd,
  input  bcs_stat_t        stat
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CP_RD  = 4'd1;
  localparam logic [3:0] S_CP_WR  = 4'd2;
  localparam logic [3:0] S_LV_RD  = 4'd3;
  localparam logic [3:0] S_LV_A   = 4'd4;
  localparam logic [3:0] S_B_RD   = 4'd5;
  localparam logic [3:0] S_B_LD   = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_DSTART = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_WR     = 4'd10;
  localparam logic [3:0] S_FIN_RD = 4'd11;
  localparam logic [3:0] S_FIN_SV = 4'd12;
  localparam logic [3:0] S_EMIT   = 4'd13;

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             ovf, ovf_next;
  logic [SEG_W-1:0] seg;
  logic [SEG_W-1:0] s, s_next;
  logic [CNT_W-1:0] n, n_next;
  logic [SEG_W-1:0] i, i_next;
  logic [1:0]       axis, axis_next;
  logic [CNT_W-1:0] k, k_next;
  logic [CNT_W-1:0] level, level_next;
  logic             mv, mv_next;
  logic             room;

  assign room      = (cnt < CNT_W'(MAX_POINTS));
  assign in_ready  = (state == S_IDLE);
  assign out_valid = mv;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ovf_next   = ovf;
    s_next     = s;
    n_next     = n;
    i_next     = i;
    axis_next  = axis;
    k_next     = k;
    level_next = level;
    mv_next    = (mv && out_ready) ? 1'b0 : mv;

    cmd           = '0;
    cmd.axis      = axis;
    cmd.cp_addr   = k[ADDR_W-1:0];
    cmd.wk_waddr  = k[ADDR_W-1:0];
    cmd.wk_raddr  = '0;
    cmd.ovf       = ovf;
    cmd.i         = i;
    cmd.s         = s;

    unique case (state)
      S_IDLE: begin
        cmd.cp_addr = cnt[ADDR_W-1:0];
        if (in_valid) begin
          cmd.cp_we = room;
          cnt_next  = room ? cnt + 1'b1 : cnt;
          ovf_next  = ovf | !room;
          if (in_last) begin
            s_next     = (seg == '0) ? SEG_W'(1) : seg;
            n_next     = room ? cnt + 1'b1 : cnt;
            i_next     = '0;
            axis_next  = AXIS_X;
            k_next     = '0;
            state_next = S_CP_RD;
          end
        end
      end
      S_CP_RD: state_next = S_CP_WR;
      S_CP_WR: begin
        cmd.wk_we     = 1'b1;
        cmd.wk_src_cp = 1'b1;
        k_next        = k + 1'b1;
        if (k + 1'b1 == n) begin
          level_next = n - 1'b1;
          state_next = (n == CNT_W'(1)) ? S_FIN_RD : S_LV_RD;
        end else begin
          state_next = S_CP_RD;
        end
      end
      S_LV_RD: begin
        k_next     = '0;
        state_next = S_LV_A;
      end
      S_LV_A: begin
        cmd.load_a = 1'b1;
        state_next = S_B_RD;
      end
      S_B_RD: begin
        cmd.wk_raddr = ADDR_W'(k + 1'b1);
        state_next   = S_B_LD;
      end
      S_B_LD: begin
        cmd.load_b = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (!stat.div_busy)
          state_next = S_WR;
      end
      S_WR: begin
        cmd.wk_we    = 1'b1;
        cmd.a_from_b = 1'b1;
        k_next       = k + 1'b1;
        if (k + 1'b1 == level) begin
          level_next = level - 1'b1;
          state_next = (level == CNT_W'(1)) ? S_FIN_RD : S_LV_RD;
        end else begin
          state_next = S_B_RD;
        end
      end
      S_FIN_RD: state_next = S_FIN_SV;
      S_FIN_SV: begin
        cmd.save_axis = 1'b1;
        k_next        = '0;
        if (axis == AXIS_Z) begin
          state_next = S_EMIT;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = S_CP_RD;
        end
      end
      S_EMIT: begin
        if (!mv || out_ready) begin
          cmd.load_out = 1'b1;
          mv_next      = 1'b1;
          axis_next    = AXIS_X;
          k_next       = '0;
          if (i == s) begin
            cnt_next   = '0;
            ovf_next   = 1'b0;
            state_next = S_IDLE;
          end else begin
            i_next     = i + 1'b1;
            state_next = S_CP_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      ovf   <= 1'b0;
      seg   <= SEG_RESET;
      mv    <= 1'b0;
      s     <= SEG_W'(1);
      n     <= '0;
      i     <= '0;
      axis  <= AXIS_X;
      k     <= '0;
      level <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ovf   <= ovf_next;
      mv    <= mv_next;
      s     <= s_next;
      n     <= n_next;
      i     <= i_next;
      axis  <= axis_next;
      k     <= k_next;
      level <= level_next;
      if (cfg_wen)
        seg <= cfg_wdata;
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// testbench for bezier_curve_sampler: streams control point curves, predicts every sample
// with its own de casteljau model in a scoreboard class; depends on bcs_pkg and the rtl
module tb;
  import bcs_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;

  typedef struct {
    logic [COORD_BITS-1:0] x, y, z;
    logic [SEG_W-1:0]      idx;
    logic                  drop, last;
  } sample_t;

  class curve_scoreboard;
    longint      ctrl_pts[MAX_POINTS][3];
    int unsigned stored;
    bit          dropped;
    int unsigned segments = 20;
    sample_t     pending[$];
    int          errors;
    int          matched;
    int          curves;

    function longint round_div(longint num, longint den);
      longint n2, d2;
      n2 = 2 * num + den;
      d2 = 2 * den;
      if (n2 >= 0) return n2 / d2;
      return -((-n2 + d2 - 1) / d2);
    endfunction

    function logic [COORD_BITS-1:0] eval_axis(int axis, int n, longint i, longint s);
      longint work[MAX_POINTS];
      longint v;
      if (n == 0) return '0;
      for (int k = 0; k < n; k++) work[k] = ctrl_pts[k][axis] <<< GUARD_BITS;
      for (int level = n - 1; level >= 1; level--)
        for (int k = 0; k < level; k++)
          work[k] = work[k] + round_div((work[k+1] - work[k]) * i, s);
      v = round_div(work[0], longint'(1) << GUARD_BITS);
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return v[COORD_BITS-1:0];
    endfunction

    function void note_input(logic [COORD_BITS-1:0] x, y, z, logic last);
      int unsigned s;
      sample_t e;
      if (stored < MAX_POINTS) begin
        ctrl_pts[stored][0] = longint'($signed(x));
        ctrl_pts[stored][1] = longint'($signed(y));
        ctrl_pts[stored][2] = longint'($signed(z));
        stored++;
      end else begin
        dropped = 1;
      end
      if (!last) return;
      s = (segments == 0) ? 1 : segments;
      for (int i = 0; i <= s; i++) begin
        e.x = eval_axis(0, stored, i, s);
        e.y = eval_axis(1, stored, i, s);
        e.z = eval_axis(2, stored, i, s);
        e.idx = SEG_W'(i);
        e.drop = dropped;
        e.last = (i == s);
        pending = {pending, e};
      end
      stored = 0;
      dropped = 0;
      curves++;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check(sample_t got);
      sample_t e;
      if (pending.size() == 0) begin
        report("sample with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x) report($sformatf("curve_x %h exp %h idx %0d", got.x, e.x, e.idx));
      if (got.y !== e.y) report($sformatf("curve_y %h exp %h idx %0d", got.y, e.y, e.idx));
      if (got.z !== e.z) report($sformatf("curve_z %h exp %h idx %0d", got.z, e.z, e.idx));
      if (got.idx !== e.idx) report($sformatf("sample_index %0d exp %0d", got.idx, e.idx));
      if (got.drop !== e.drop) report($sformatf("points_dropped %b exp %b", got.drop, e.drop));
      if (got.last !== e.last) report($sformatf("last_sample %b exp %b", got.last, e.last));
      matched++;
    endtask
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_wen = 0;
  logic [SEG_W-1:0]   cfg_wdata = '0;
  logic               s_tvalid = 0;
  logic               s_tready;
  logic [IN_PAD-1:0]  s_tdata = '0;
  logic               s_tlast = 0;
  logic               m_tvalid;
  logic               m_tready = 0;
  logic [OUT_PAD-1:0] m_tdata;
  logic               m_tuser;
  logic               m_tlast;

  curve_scoreboard sb = new;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int points_sent = 0;
  int watchdog = 0;

  bezier_curve_sampler DUT (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    sample_t got;
    if (!rst && s_tvalid && s_tready) begin
      sb.note_input(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tlast);
      points_sent++;
    end
    if (!rst && m_tvalid && m_tready) begin
      got.x = m_tdata[15:0];
      got.y = m_tdata[31:16];
      got.z = m_tdata[47:32];
      got.idx = m_tdata[53:48];
      got.drop = m_tuser;
      got.last = m_tlast;
      sb.check(got);
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen || rst) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d samples pending", sb.pending.size());
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task send_point(logic [15:0] x, y, z, logic last);
    int gap, seen;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(8, 1) : 0;
    if (gap > 0) begin
      s_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    s_tdata = {x, z, y} == 0 ? '0 : {z, y, x};
    s_tlast = last;
    s_tvalid = 1;
    seen = points_sent;
    while (points_sent == seen) @(negedge clk);
  endtask

  task drain;
    s_tvalid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task write_segments(logic [SEG_W-1:0] value);
    drain();
    cfg_wdata = value;
    cfg_wen = 1;
    @(negedge clk);
    cfg_wen = 0;
    sb.segments = value;
  endtask

  function logic [15:0] rand_coord();
    case ($urandom_range(9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task send_curve(int n);
    for (int k = 0; k < n; k++)
      send_point(rand_coord(), rand_coord(), rand_coord(), k == n - 1);
  endtask

  initial begin
    int n;
    repeat (4) @(negedge clk);
    rst = 0;
    @(negedge clk);

    // reset segment count, single point and two extreme points
    send_point(16'h7fff, 16'h8000, 16'h1234, 1);
    send_point(16'h8000, 16'h7fff, 16'h0000, 0);
    send_point(16'h7fff, 16'h8000, 16'hffff, 1);
    write_segments(0);
    send_curve(3);
    write_segments(63);
    send_point(16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_point(16'h8000, 16'h8000, 16'h8000, 0);
    send_point(16'h7fff, 16'h7fff, 16'h7fff, 1);
    write_segments(1);
    // more points than capacity, last one dropped too
    for (int k = 0; k < MAX_POINTS + 2; k++)
      send_point(16'($urandom), 16'($urandom), 16'($urandom), k == MAX_POINTS + 1);

    for (int phase = 0; phase < 8; phase++) begin
      write_segments(SEG_W'(phase == 7 ? 63 : $urandom_range(12)));
      case (phase / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int c = 0; c < 7; c++) begin
        n = $urandom_range(5, 1);
        if (phase == 7) n = $urandom_range(3, 1);
        send_curve(n);
        if (phase == 3 && c == 2) drain();
      end
    end

    drain();
    repeat (200) @(negedge clk);
    $display("run covered %0d control points in %0d curves, %0d samples checked",
             points_sent, sb.curves, sb.matched);
    $display("segment counts 0, 1, 20, 63 and random, capacity overflow, four idle patterns");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
